// File: rtl/mroe_pkg.sv
// ----------------------------------------------------------------------------
// mroe_pkg
// Shared types and codes for the matrix row operation engine: item modes,
// status codes, Q16.16 entry type and the arithmetic unit control group.
// ----------------------------------------------------------------------------
package mroe_pkg;

   localparam int MODE_W   = 3;
   localparam int ROW_W    = 4;
   localparam int COL_W    = 3;
   localparam int CSR_W    = 4;
   localparam int STATUS_W = 2;
   localparam int DATA_W   = 32;
   localparam int MAG_W    = 31;
   localparam int PROD_W   = 2 * DATA_W;

   localparam logic [MODE_W-1:0] MODE_WRITE = 3'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SWAP  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SCALE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ADD   = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ROW = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO    = 2'd2;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [MAG_W-1:0]         mag_type;

   localparam data_type DATA_MAX = 32'sh7FFF_FFFF;
   localparam data_type DATA_MIN = 32'sh8000_0000;
   localparam mag_type  MAG_MAX  = 31'h7FFF_FFFF;

   typedef struct packed {
      logic mul_en;
      logic rnd_en;
      logic sum_en;
      logic add_mode;
   } alu_ctl_type;

endpackage

// File: rtl/mroe_store.sv
// ----------------------------------------------------------------------------
// mroe_store
// Matrix entry memory, row-major, one write port and two registered read
// ports with a read enable so that read data holds between reads.
// ----------------------------------------------------------------------------
module mroe_store #(
   parameter  int MAX_DIM = 8,
   localparam int DEPTH   = MAX_DIM * MAX_DIM,
   localparam int AW      = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  mroe_pkg::data_type wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr_a,
   input  logic [AW-1:0]      rd_addr_b,
   output mroe_pkg::data_type rd_data_a,
   output mroe_pkg::data_type rd_data_b
);
   import mroe_pkg::*;

   data_type mem [DEPTH];
   data_type rd_a_ff;
   data_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// File: rtl/mroe_alu.sv
// ----------------------------------------------------------------------------
// mroe_alu
// Q16.16 multiply, round half up with saturation, then optional saturating
// add of the target entry; one registered step per stage.
// ----------------------------------------------------------------------------
module mroe_alu (
   input  logic                  clock,
   input  mroe_pkg::alu_ctl_type ctl,
   input  mroe_pkg::data_type    entry_a,
   input  mroe_pkg::data_type    entry_b,
   input  mroe_pkg::data_type    factor,
   output mroe_pkg::data_type    result
);
   import mroe_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] rounded;
   logic signed [DATA_W:0]   total;
   data_type                 operand;
   data_type                 scaled_ff;
   data_type                 scaled_in;
   data_type                 result_ff;
   data_type                 result_in;

   always_comb begin
      operand = ctl.add_mode ? entry_b : entry_a;
      prod_in = PROD_W'(operand) * PROD_W'(factor);
   end

   // floor shift after adding half an lsb
   always_comb begin
      rounded = (prod_ff + 64'sd32768) >>> 16;
      if (rounded > 64'sd2147483647) begin
         scaled_in = DATA_MAX;
      end else if (rounded < -64'sd2147483648) begin
         scaled_in = DATA_MIN;
      end else begin
         scaled_in = rounded[DATA_W-1:0];
      end
   end

   always_comb begin
      total = (DATA_W + 1)'(entry_a) + (DATA_W + 1)'(scaled_ff);
      if (!ctl.add_mode) begin
         result_in = scaled_ff;
      end else if (total[DATA_W] != total[DATA_W-1]) begin
         result_in = total[DATA_W] ? DATA_MIN : DATA_MAX;
      end else begin
         result_in = total[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctl.rnd_en) begin
         scaled_ff <= scaled_in;
      end
      if (ctl.sum_en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// File: rtl/matrix_row_operation_engine.sv
// ----------------------------------------------------------------------------
// matrix_row_operation_engine
// Square matrix of Q16.16 entries with entry write/read and elementary row
// operations (swap, scale, add scaled row), saturating arithmetic and a
// running largest magnitude.
//
//   channel   handshake            payload
//   request   start / busy         req_mode, req_first_row, req_second_row,
//                                  req_column_index, req_entry_value,
//                                  req_scale_factor
//   response  rsp_valid (strobe)   rsp_status, rsp_read_value,
//                                  rsp_max_magnitude
//   config    csr_valid/csr_ready  csr_data (active column count)
//
// Write, read, error and unused modes pass execute and finish to the strobe.
// Swap, scale and add loop over the N active columns, one per pass through
// the single-write memory: read, write A, write B for swap; read, multiply,
// round, sum, write for scale and add. busy is high from the transfer until
// the strobe; the strobe lasts one cycle and the response cannot be held.
// csr_ready is high while idle. Reset clears control, the column count (to
// 8) and the largest magnitude; matrix entries are undefined until written.
// ----------------------------------------------------------------------------
module matrix_row_operation_engine #(
   parameter int MAX_DIM = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [mroe_pkg::MODE_W-1:0]           req_mode,
   input  logic [mroe_pkg::ROW_W-1:0]            req_first_row,
   input  logic [mroe_pkg::ROW_W-1:0]            req_second_row,
   input  logic [mroe_pkg::COL_W-1:0]            req_column_index,
   input  mroe_pkg::data_type                    req_entry_value,
   input  mroe_pkg::data_type                    req_scale_factor,
   output logic                                  rsp_valid,
   output logic [mroe_pkg::STATUS_W-1:0]         rsp_status,
   output mroe_pkg::data_type                    rsp_read_value,
   output mroe_pkg::mag_type                     rsp_max_magnitude,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mroe_pkg::CSR_W-1:0]            csr_data
);
   import mroe_pkg::*;

   localparam int AW = $clog2(MAX_DIM * MAX_DIM);
   localparam int CW = $clog2(MAX_DIM);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_EXEC  = 4'd1;
   localparam logic [3:0] S_READ  = 4'd2;
   localparam logic [3:0] S_SWPA  = 4'd3;
   localparam logic [3:0] S_SWPB  = 4'd4;
   localparam logic [3:0] S_MUL   = 4'd5;
   localparam logic [3:0] S_RND   = 4'd6;
   localparam logic [3:0] S_SUM   = 4'd7;
   localparam logic [3:0] S_WRITE = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;

   function automatic mag_type magnitude(input data_type v);
      data_type neg;
      neg = -v;
      if (!v[DATA_W-1]) begin
         return v[MAG_W-1:0];
      end else if (v == DATA_MIN) begin
         return MAG_MAX;
      end else begin
         return neg[MAG_W-1:0];
      end
   endfunction

   logic [3:0]          state_ff, state_in;
   logic [CSR_W-1:0]    active_ff, active_in;
   mag_type             largest_ff, largest_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   data_type            rsp_value_ff, rsp_value_in;

   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [AW-1:0]       base_a_ff, base_a_in;
   logic [AW-1:0]       base_b_ff, base_b_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [CSR_W-1:0]    remain_ff, remain_in;
   data_type            value_ff, value_in;
   data_type            factor_ff, factor_in;

   logic                accept;
   logic                row1_ok;
   logic                row2_ok;
   logic                col_ok;
   logic [CSR_W-1:0]    ncols;
   logic                last_col;
   logic [AW-1:0]       addr_a;
   logic [AW-1:0]       addr_b;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   data_type            wr_data;
   logic                rd_en;
   data_type            rd_a;
   data_type            rd_b;
   alu_ctl_type         alu_ctl;
   data_type            alu_result;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);

   assign row1_ok = (req_first_row != '0) && (int'(req_first_row) <= MAX_DIM);
   assign row2_ok = (req_second_row != '0) && (int'(req_second_row) <= MAX_DIM);
   assign col_ok  = (int'(req_column_index) < MAX_DIM);

   assign ncols    = (int'(active_ff) > MAX_DIM) ? CSR_W'(MAX_DIM) : active_ff;
   assign last_col = (remain_ff == CSR_W'(1));
   assign addr_a   = base_a_ff + AW'(col_ff);
   assign addr_b   = base_b_ff + AW'(col_ff);

   always_comb begin
      unique case (req_mode) inside
         MODE_WRITE, MODE_READ: begin
            status_in = (row1_ok && col_ok) ? STATUS_OK : STATUS_BAD_ROW;
         end
         MODE_SWAP: begin
            status_in = (row1_ok && row2_ok) ? STATUS_OK : STATUS_BAD_ROW;
         end
         MODE_SCALE: begin
            if (!row1_ok) begin
               status_in = STATUS_BAD_ROW;
            end else if (req_scale_factor == '0) begin
               status_in = STATUS_ZERO;
            end else begin
               status_in = STATUS_OK;
            end
         end
         MODE_ADD: begin
            if (!row1_ok || !row2_ok) begin
               status_in = STATUS_BAD_ROW;
            end else if (req_scale_factor == '0) begin
               status_in = STATUS_ZERO;
            end else begin
               status_in = STATUS_OK;
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      active_in     = active_ff;
      largest_in    = largest_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      mode_in       = mode_ff;
      base_a_in     = base_a_ff;
      base_b_in     = base_b_ff;
      col_in        = col_ff;
      remain_in     = remain_ff;
      value_in      = value_ff;
      factor_in     = factor_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_a;
      wr_data       = alu_result;
      rd_en         = 1'b0;
      alu_ctl       = '{mul_en: 1'b0, rnd_en: 1'b0, sum_en: 1'b0,
                        add_mode: (mode_ff == MODE_ADD)};

      if (csr_valid && csr_ready) begin
         active_in = csr_data;
      end

      unique case (state_ff) inside
         S_IDLE: begin
            if (accept) begin
               mode_in   = req_mode;
               base_a_in = AW'(AW'(req_first_row - ROW_W'(1)) * AW'(MAX_DIM));
               base_b_in = AW'(AW'(req_second_row - ROW_W'(1)) * AW'(MAX_DIM));
               col_in    = CW'(req_column_index);
               value_in  = req_entry_value;
               factor_in = req_scale_factor;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FIN;
            if (status_ff == STATUS_OK) begin
               case (mode_ff) inside
                  MODE_WRITE: begin
                     wr_en   = 1'b1;
                     wr_data = value_ff;
                  end
                  MODE_READ: begin
                     rd_en = 1'b1;
                  end
                  MODE_SWAP, MODE_SCALE, MODE_ADD: begin
                     col_in    = '0;
                     remain_in = ncols;
                     if (ncols != '0) begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = (mode_ff == MODE_SWAP) ? S_SWPA : S_MUL;
         end
         S_SWPA: begin
            wr_en    = 1'b1;
            wr_data  = rd_b;
            state_in = S_SWPB;
         end
         S_MUL: begin
            alu_ctl.mul_en = 1'b1;
            state_in       = S_RND;
         end
         S_RND: begin
            alu_ctl.rnd_en = 1'b1;
            state_in       = S_SUM;
         end
         S_SUM: begin
            alu_ctl.sum_en = 1'b1;
            state_in       = S_WRITE;
         end
         S_SWPB, S_WRITE: begin
            wr_en = 1'b1;
            if (state_ff == S_SWPB) begin
               wr_addr = addr_b;
               wr_data = rd_a;
            end else if (magnitude(alu_result) > largest_ff) begin
               largest_in = magnitude(alu_result);
            end
            if (last_col) begin
               state_in = S_FIN;
            end else begin
               col_in    = col_ff + CW'(1);
               remain_in = remain_ff - CSR_W'(1);
               state_in  = S_READ;
            end
         end
         S_FIN: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_value_in  = (mode_ff == MODE_READ && status_ff == STATUS_OK) ? rd_a : '0;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= CSR_W'(8);
         largest_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         largest_ff   <= largest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      mode_ff       <= mode_in;
      base_a_ff     <= base_a_in;
      base_b_ff     <= base_b_in;
      col_ff        <= col_in;
      remain_ff     <= remain_in;
      value_ff      <= value_in;
      factor_ff     <= factor_in;
      if (accept) begin
         status_ff <= status_in;
      end
   end

   mroe_store #(
      .MAX_DIM (MAX_DIM)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (addr_a),
      .rd_addr_b (addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   mroe_alu u_alu (
      .clock   (clock),
      .ctl     (alu_ctl),
      .entry_a (rd_a),
      .entry_b (rd_b),
      .factor  (factor_ff),
      .result  (alu_result)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_read_value    = rsp_value_ff;
   assign rsp_max_magnitude = largest_ff;

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the matrix row operation engine. A mirror of the
// matrix, the column count and the running peak magnitude predicts every
// response, which is compared field by field as it strobes out. Directed
// items cover entry access, the row operations and saturation; random items
// run under several column counts with random gaps on the request and
// register sides.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mroe_pkg::*;

   localparam int DIM   = 8;
   localparam int LIMIT = 400000;
   localparam int DRAIN_CYCLES = 64;
   localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [ROW_W-1:0]  first_row;
      logic [ROW_W-1:0]  second_row;
      logic [COL_W-1:0]  column;
      data_type          entry;
      data_type          factor;
   } row_item_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      data_type            read_value;
      mag_type             max_mag;
   } outcome_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [MODE_W-1:0]   req_mode;
   logic [ROW_W-1:0]    req_first_row;
   logic [ROW_W-1:0]    req_second_row;
   logic [COL_W-1:0]    req_column_index;
   data_type            req_entry_value;
   data_type            req_scale_factor;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   data_type            rsp_read_value;
   mag_type             rsp_max_magnitude;
   logic                csr_valid;
   logic                csr_ready;
   logic [CSR_W-1:0]    csr_data;

   // mirror of the engine state
   data_type         mirror [DIM*DIM];
   bit               written [DIM*DIM];
   mag_type          peak;
   logic [CSR_W-1:0] col_count;

   outcome_type awaited_outcomes [$];
   bit          start_held;
   bit          steady;
   int          errors;
   int          items_sent;
   int          results_seen;
   int          cfg_writes;
   int          cycle_count;

   matrix_row_operation_engine #(
      .MAX_DIM(DIM)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_first_row     (req_first_row),
      .req_second_row    (req_second_row),
      .req_column_index  (req_column_index),
      .req_entry_value   (req_entry_value),
      .req_scale_factor  (req_scale_factor),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_read_value    (rsp_read_value),
      .rsp_max_magnitude (rsp_max_magnitude),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   // saturating Q16.16 arithmetic
   function automatic data_type saturate(longint v);
      if (v > longint'(DATA_MAX)) return DATA_MAX;
      if (v < longint'(DATA_MIN)) return DATA_MIN;
      return data_type'(v);
   endfunction

   function automatic data_type q_mul(data_type a, data_type b);
      longint p;
      p = longint'(a) * longint'(b) + 64'sd32768;
      return saturate(p >>> 16);
   endfunction

   function automatic void note_peak(data_type v);
      mag_type m;
      if (v == DATA_MIN) m = MAG_MAX;
      else if (v < 0) m = mag_type'(-v);
      else m = mag_type'(v);
      if (m > peak) peak = m;
   endfunction

   function automatic bit row_valid(logic [ROW_W-1:0] r);
      return r >= 1 && r <= DIM;
   endfunction

   function automatic int active_cols();
      return (col_count > DIM) ? DIM : int'(col_count);
   endfunction

   function automatic outcome_type apply_row_item(row_item_type it);
      outcome_type o;
      int          a;
      int          b;
      int          n;
      data_type    t;
      data_type    pr;
      o.status = STATUS_OK;
      o.read_value = '0;
      n = active_cols();
      a = (int'(it.first_row) - 1) * DIM;
      b = (int'(it.second_row) - 1) * DIM;
      case (it.mode) inside
         MODE_WRITE, MODE_READ: begin
            if (!row_valid(it.first_row)) begin
               o.status = STATUS_BAD_ROW;
            end else if (it.mode == MODE_WRITE) begin
               mirror[a + it.column] = it.entry;
               written[a + it.column] = 1'b1;
            end else begin
               o.read_value = mirror[a + it.column];
            end
         end
         MODE_SWAP: begin
            if (!row_valid(it.first_row) || !row_valid(it.second_row)) begin
               o.status = STATUS_BAD_ROW;
            end else begin
               for (int i = 0; i < n; i++) begin
                  t = mirror[a + i];
                  mirror[a + i] = mirror[b + i];
                  mirror[b + i] = t;
               end
            end
         end
         MODE_SCALE: begin
            if (!row_valid(it.first_row)) begin
               o.status = STATUS_BAD_ROW;
            end else if (it.factor == 0) begin
               o.status = STATUS_ZERO;
            end else begin
               for (int i = 0; i < n; i++) begin
                  mirror[a + i] = q_mul(mirror[a + i], it.factor);
                  note_peak(mirror[a + i]);
               end
            end
         end
         MODE_ADD: begin
            if (!row_valid(it.first_row) || !row_valid(it.second_row)) begin
               o.status = STATUS_BAD_ROW;
            end else if (it.factor == 0) begin
               o.status = STATUS_ZERO;
            end else begin
               for (int i = 0; i < n; i++) begin
                  pr = q_mul(mirror[b + i], it.factor);
                  mirror[a + i] = saturate(longint'(mirror[a + i]) + longint'(pr));
                  note_peak(mirror[a + i]);
               end
            end
         end
         default: ;
      endcase
      o.max_mag = peak;
      return o;
   endfunction

   // index of the first entry an item would read before it was written
   function automatic int row_gap(logic [ROW_W-1:0] r);
      int base;
      base = (int'(r) - 1) * DIM;
      for (int i = 0; i < active_cols(); i++)
         if (!written[base + i]) return base + i;
      return -1;
   endfunction

   function automatic int first_gap(row_item_type it);
      int g;
      g = -1;
      case (it.mode) inside
         MODE_READ: begin
            if (row_valid(it.first_row)
                && !written[(int'(it.first_row) - 1) * DIM + it.column])
               g = (int'(it.first_row) - 1) * DIM + it.column;
         end
         MODE_SWAP, MODE_ADD: begin
            if (row_valid(it.first_row) && row_valid(it.second_row)
                && (it.mode == MODE_SWAP || it.factor != 0)) begin
               g = row_gap(it.first_row);
               if (g < 0) g = row_gap(it.second_row);
            end
         end
         MODE_SCALE: begin
            if (row_valid(it.first_row) && it.factor != 0) g = row_gap(it.first_row);
         end
         default: ;
      endcase
      return g;
   endfunction

   function automatic data_type pick_entry();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 50) return data_type'(int'($urandom_range(0, 2097152)) - 1048576);
      if (sel < 80) return data_type'($urandom);
      case ($urandom_range(0, 3))
         0: return DATA_MAX;
         1: return DATA_MIN;
         2: return data_type'(0);
         default: return data_type'(-1);
      endcase
   endfunction

   function automatic data_type pick_factor();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 8) return data_type'(0);
      if (sel < 70) return data_type'(int'($urandom_range(0, 163840)) - 81920);
      if (sel < 80) return data_type'($urandom);
      case ($urandom_range(0, 5))
         0: return DATA_MAX;
         1: return DATA_MIN;
         2: return data_type'(32'sh0001_0000);
         3: return data_type'(-32'sh0001_0000);
         4: return data_type'(32'sh0000_8000);
         default: return data_type'(1);
      endcase
   endfunction

   function automatic logic [ROW_W-1:0] pick_row();
      if ($urandom_range(0, 99) < 6) return '0;
      return ROW_W'($urandom_range(1, DIM));
   endfunction

   function automatic row_item_type random_item();
      row_item_type it;
      int           sel;
      int           g;
      sel = $urandom_range(0, 99);
      if (sel < 25) it.mode = MODE_WRITE;
      else if (sel < 40) it.mode = MODE_READ;
      else if (sel < 55) it.mode = MODE_SWAP;
      else if (sel < 75) it.mode = MODE_SCALE;
      else if (sel < 95) it.mode = MODE_ADD;
      else it.mode = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
      it.first_row = pick_row();
      it.second_row = pick_row();
      it.column = COL_W'($urandom_range(0, DIM - 1));
      it.entry = pick_entry();
      it.factor = pick_factor();
      g = first_gap(it);
      if (g >= 0) begin
         it.mode = MODE_WRITE;
         it.first_row = ROW_W'(g / DIM + 1);
         it.column = COL_W'(g % DIM);
      end
      return it;
   endfunction

   function automatic row_item_type make_item(logic [MODE_W-1:0] mode, int r1, int r2,
                                              int col, data_type entry, data_type factor);
      row_item_type it;
      it.mode = mode;
      it.first_row = ROW_W'(r1);
      it.second_row = ROW_W'(r2);
      it.column = COL_W'(col);
      it.entry = entry;
      it.factor = factor;
      return it;
   endfunction

   task automatic send_item(row_item_type it);
      while (!steady && $urandom_range(0, 99) < 31) begin
         if (start_held) begin
            start <= 1'b0;
            start_held = 1'b0;
         end
         @(posedge clock);
      end
      start <= 1'b1;
      start_held = 1'b1;
      req_mode <= it.mode;
      req_first_row <= it.first_row;
      req_second_row <= it.second_row;
      req_column_index <= it.column;
      req_entry_value <= it.entry;
      req_scale_factor <= it.factor;
      @(posedge clock);
      while (busy) @(posedge clock);
      awaited_outcomes.push_back(apply_row_item(it));
      items_sent++;
   endtask

   task automatic drain();
      if (start_held) begin
         start <= 1'b0;
         start_held = 1'b0;
      end
      while (awaited_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic set_columns(logic [CSR_W-1:0] n);
      drain();
      while (!steady && $urandom_range(0, 99) < 31) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= n;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      col_count = n;
      cfg_writes++;
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid) begin
         if (awaited_outcomes.size() == 0) begin
            $error("response transfer with nothing outstanding");
            errors++;
         end else begin
            want = awaited_outcomes.pop_front();
            results_seen++;
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_read_value !== want.read_value) begin
               $error("read_value: expected %h, got %h", want.read_value, rsp_read_value);
               errors++;
            end
            if (rsp_max_magnitude !== want.max_mag) begin
               $error("max_magnitude: expected %h, got %h", want.max_mag,
                      rsp_max_magnitude);
               errors++;
            end
         end
      end
   end

   task automatic test_entry_access();
      send_item(make_item(MODE_WRITE, 1, 0, 0, 32'sh0001_8000, 0));
      send_item(make_item(MODE_WRITE, 1, 0, 1, -32'sh0002_8000, 0));
      send_item(make_item(MODE_WRITE, 2, 0, 0, 32'sh0001_0000, 0));
      send_item(make_item(MODE_WRITE, 2, 0, 1, 32'sh0000_0001, 0));
      send_item(make_item(MODE_WRITE, 8, 0, 7, DATA_MAX, 0));
      send_item(make_item(MODE_WRITE, 8, 0, 6, DATA_MIN, 0));
      send_item(make_item(MODE_READ, 8, 0, 7, 0, 0));
      send_item(make_item(MODE_READ, 8, 0, 6, 0, 0));
      send_item(make_item(MODE_WRITE, 0, 0, 3, DATA_MAX, 0));
      send_item(make_item(MODE_READ, 0, 0, 0, 0, 0));
      send_item(make_item(MODE_SPARE_FIRST, 1, 1, 0, DATA_MIN, DATA_MAX));
      send_item(make_item(MODE_SPARE_LAST, 8, 8, 7, DATA_MAX, DATA_MIN));
      drain();
   endtask

   task automatic test_row_ops();
      set_columns(4'd2);
      send_item(make_item(MODE_SWAP, 1, 2, 0, 0, 0));
      send_item(make_item(MODE_SWAP, 2, 2, 0, 0, 0));
      send_item(make_item(MODE_SWAP, 0, 1, 0, 0, 0));
      send_item(make_item(MODE_SCALE, 1, 0, 0, 0, 32'sh0000_8000));
      send_item(make_item(MODE_SCALE, 2, 0, 0, 0, -32'sh0000_8000));
      send_item(make_item(MODE_SCALE, 1, 0, 0, 0, 0));
      send_item(make_item(MODE_SCALE, 0, 0, 0, 0, 0));
      send_item(make_item(MODE_ADD, 1, 2, 0, 0, -32'sh0001_0000));
      send_item(make_item(MODE_ADD, 2, 2, 0, 0, 32'sh0000_8000));
      send_item(make_item(MODE_ADD, 1, 0, 0, 0, 32'sh0001_0000));
      send_item(make_item(MODE_ADD, 1, 2, 0, 0, 0));
      send_item(make_item(MODE_READ, 1, 0, 1, 0, 0));
      drain();
   endtask

   task automatic test_random_mix();
      logic [CSR_W-1:0] settings [6];
      settings = '{4'd8, 4'd1, 4'd4, 4'd8, 4'd2, CSR_W'($urandom_range(1, 8))};
      for (int p = 0; p < 6; p++) begin
         set_columns(settings[p]);
         steady = (p == 2);
         for (int k = 0; k < 210; k++) send_item(random_item());
         drain();
      end
      steady = 1'b0;
   endtask

   task automatic test_saturation();
      set_columns(4'd1);
      send_item(make_item(MODE_WRITE, 7, 0, 0, DATA_MAX, 0));
      send_item(make_item(MODE_SCALE, 7, 0, 0, 0, DATA_MAX));
      send_item(make_item(MODE_WRITE, 6, 0, 0, DATA_MIN, 0));
      send_item(make_item(MODE_ADD, 6, 6, 0, 0, 32'sh0001_0000));
      send_item(make_item(MODE_SCALE, 7, 0, 0, 0, DATA_MIN));
      send_item(make_item(MODE_READ, 7, 0, 0, 0, 0));
      drain();
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_mode <= MODE_WRITE;
      req_first_row <= '0;
      req_second_row <= '0;
      req_column_index <= '0;
      req_entry_value <= '0;
      req_scale_factor <= '0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      start_held = 1'b0;
      steady = 1'b0;
      peak = '0;
      col_count = 4'd8;
      foreach (mirror[i]) begin
         mirror[i] = '0;
         written[i] = 1'b0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_entry_access();
      test_row_ops();
      test_random_mix();
      test_saturation();

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d items and %0d column settings sent, %0d responses checked",
               items_sent, cfg_writes, results_seen);
      $display("peak magnitude %h, %0d mismatches", peak, errors);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/mroe_pkg.sv
rtl/mroe_store.sv
rtl/mroe_alu.sv
rtl/matrix_row_operation_engine.sv
bench/tb.sv
